FILE: src/blts_pkg.sv
// ----------------------------------------------------------------------------
// blts_pkg
// Shared constants and types for the block-linear texel swizzle: register
// indexes, reset values and field widths.
// ----------------------------------------------------------------------------
package blts_pkg;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;

	typedef logic [CFG_IDX_BITS-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;

	localparam cfg_idx_t REG_IMAGE_WIDTH  = 3'd0;
	localparam cfg_idx_t REG_IMAGE_HEIGHT = 3'd1;
	localparam cfg_idx_t REG_BPT          = 3'd2;
	localparam cfg_idx_t REG_BH_LOG2      = 3'd3;
	localparam cfg_idx_t REG_WIDTH_PAD    = 3'd4;
	localparam cfg_idx_t REG_HEIGHT_PAD   = 3'd5;
	localparam cfg_idx_t REG_TOTAL_BYTES  = 3'd6;

	localparam int SIZE_BITS  = 15;
	localparam int BPT_BITS   = 4;
	localparam int BHL_BITS   = 3;
	localparam int PAD_BITS   = 7;
	localparam int TOTAL_BITS = 32;
	localparam int DIV_BITS   = 16;
	localparam int GOBS_BITS  = 13;
	localparam int TEXEL_BITS = 64;

	localparam logic [SIZE_BITS-1:0]  RST_IMAGE_WIDTH  = 15'd256;
	localparam logic [SIZE_BITS-1:0]  RST_IMAGE_HEIGHT = 15'd256;
	localparam logic [BPT_BITS-1:0]   RST_BPT          = 4'd4;
	localparam logic [BHL_BITS-1:0]   RST_BH_LOG2      = 3'd4;
	localparam logic [PAD_BITS-1:0]   RST_WIDTH_PAD    = 7'd8;
	localparam logic [PAD_BITS-1:0]   RST_HEIGHT_PAD   = 7'd8;
	localparam logic [TOTAL_BITS-1:0] RST_TOTAL_BYTES  = 32'd262144;
	localparam logic [GOBS_BITS-1:0]  RST_GOBS_WIDE    = 13'd16;

	localparam logic [SIZE_BITS-1:0]  SIZE_MAX = 15'd32767;

endpackage

FILE: src/blts_if.sv
// ----------------------------------------------------------------------------
// blts channel interfaces
// Valid/ready channels for texels in, addressed texels out and register
// writes.
// ----------------------------------------------------------------------------
interface blts_in_if #(parameter int COORD_BITS = 14);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] col;
	logic [COORD_BITS-1:0] row;
	logic [63:0]           texel_data;

	modport source (output valid, col, row, texel_data, input ready);
	modport sink   (input valid, col, row, texel_data, output ready);
endinterface

interface blts_out_if #(parameter int ADDR_BITS = 36);
	logic                 valid;
	logic                 ready;
	logic [ADDR_BITS-1:0] dest_address;
	logic [63:0]          texel_out;
	logic                 write_enable;

	modport source (output valid, dest_address, texel_out, write_enable, input ready);
	modport sink   (input valid, dest_address, texel_out, write_enable, output ready);
endinterface

interface blts_cfg_if;
	logic                valid;
	logic                ready;
	blts_pkg::cfg_idx_t  idx;
	blts_pkg::cfg_data_t data;

	modport source (output valid, idx, data, input ready);
	modport sink   (input valid, idx, data, output ready);
endinterface

FILE: src/block_linear_texture_swizzle.sv
// ----------------------------------------------------------------------------
// block_linear_texture_swizzle
// Byte address generator for a block-linear GOB surface, with bounds check.
// ----------------------------------------------------------------------------
// Each texel word gives its byte address in a surface of 64-byte by 8-row
// GOBs stacked 2^block_height_log2 high, its data unchanged and a write
// enable. The four-stage pipeline takes one texel per cycle when the output
// is ready and no configuration sequence is busy; stages advance
// independently, so bubbles close up under an output stall. Any register
// write starts a sequence (one load, two 16-step restoring dividers for
// width and height side by side, one multiply for the padded sizes, one for
// the GOB row width) during which neither channel is ready.
module block_linear_texture_swizzle #(
	parameter int COORD_BITS = 14,
	parameter int ADDR_BITS  = 36
) (
	input  logic        clk,
	input  logic        arst_n,
	blts_in_if.sink     pix_in,
	blts_out_if.source  pix_out,
	blts_cfg_if.sink    cfg
);
	import blts_pkg::*;

	localparam int XW   = COORD_BITS + BPT_BITS;
	localparam int BW   = COORD_BITS + GOBS_BITS;
	localparam int RPW  = COORD_BITS + SIZE_BITS;
	localparam int LW   = COORD_BITS + 16;
	localparam int LPW  = LW + BPT_BITS;
	localparam int CXW  = (COORD_BITS >= SIZE_BITS) ? COORD_BITS + 1 : SIZE_BITS;
	localparam int CW   = COORD_BITS + 25;
	localparam int AW   = (ADDR_BITS > CW) ? ADDR_BITS : CW;
	localparam int PVW  = DIV_BITS + PAD_BITS;
	localparam int GPW  = SIZE_BITS + BPT_BITS + 1;

	localparam logic [2:0] SEQ_IDLE = 3'd0;
	localparam logic [2:0] SEQ_LOAD = 3'd1;
	localparam logic [2:0] SEQ_DIV  = 3'd2;
	localparam logic [2:0] SEQ_PAD  = 3'd3;
	localparam logic [2:0] SEQ_GOBS = 3'd4;

	logic [SIZE_BITS-1:0]  iw_q, ih_q, pw_q, ph_q;
	logic [BPT_BITS-1:0]   bpt_q;
	logic [BHL_BITS-1:0]   bhl_q;
	logic [PAD_BITS-1:0]   wpad_q, hpad_q;
	logic [TOTAL_BITS-1:0] tot_q;
	logic [GOBS_BITS-1:0]  gobs_q;

	logic [2:0]            seq_q;
	logic [3:0]            cnt_q;
	logic [DIV_BITS-1:0]   nw_q, nh_q;
	logic [PAD_BITS:0]     rw_q, rh_q;

	logic                  busy, cfg_acc, cfg_hit;
	logic [PAD_BITS-1:0]   mw, mh;
	logic [PAD_BITS:0]     rw_sh, rh_sh;
	logic                  qw_bit, qh_bit;
	logic [PVW-1:0]        pvw, pvh;
	logic [GPW-1:0]        gprod;

	assign busy    = (seq_q != SEQ_IDLE);
	assign cfg_acc = cfg.valid && cfg.ready;
	assign cfg.ready = !busy;
	assign cfg_hit = (cfg.idx <= REG_TOTAL_BYTES);

	assign mw = (wpad_q == '0) ? PAD_BITS'(1) : wpad_q;
	assign mh = (hpad_q == '0) ? PAD_BITS'(1) : hpad_q;

	always_comb begin
		rw_sh  = {rw_q[PAD_BITS-1:0], nw_q[DIV_BITS-1]};
		rh_sh  = {rh_q[PAD_BITS-1:0], nh_q[DIV_BITS-1]};
		qw_bit = (rw_sh >= {1'b0, mw});
		qh_bit = (rh_sh >= {1'b0, mh});
		pvw    = PVW'(nw_q) * PVW'(mw);
		pvh    = PVW'(nh_q) * PVW'(mh);
		gprod  = GPW'(pw_q) * GPW'(bpt_q) + GPW'(63);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iw_q   <= RST_IMAGE_WIDTH;
			ih_q   <= RST_IMAGE_HEIGHT;
			bpt_q  <= RST_BPT;
			bhl_q  <= RST_BH_LOG2;
			wpad_q <= RST_WIDTH_PAD;
			hpad_q <= RST_HEIGHT_PAD;
			tot_q  <= RST_TOTAL_BYTES;
		end else if (cfg_acc) begin
			unique case (cfg.idx)
				REG_IMAGE_WIDTH:  iw_q   <= cfg.data[SIZE_BITS-1:0];
				REG_IMAGE_HEIGHT: ih_q   <= cfg.data[SIZE_BITS-1:0];
				REG_BPT:          bpt_q  <= cfg.data[BPT_BITS-1:0];
				REG_BH_LOG2:      bhl_q  <= cfg.data[BHL_BITS-1:0];
				REG_WIDTH_PAD:    wpad_q <= cfg.data[PAD_BITS-1:0];
				REG_HEIGHT_PAD:   hpad_q <= cfg.data[PAD_BITS-1:0];
				REG_TOTAL_BYTES:  tot_q  <= cfg.data[TOTAL_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q  <= SEQ_IDLE;
			cnt_q  <= '0;
			pw_q   <= RST_IMAGE_WIDTH;
			ph_q   <= RST_IMAGE_HEIGHT;
			gobs_q <= RST_GOBS_WIDE;
		end else begin
			unique case (seq_q)
				SEQ_IDLE: begin
					if (cfg_acc && cfg_hit) seq_q <= SEQ_LOAD;
				end
				SEQ_LOAD: begin
					cnt_q <= '0;
					seq_q <= SEQ_DIV;
				end
				SEQ_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) seq_q <= SEQ_PAD;
				end
				SEQ_PAD: begin
					pw_q  <= (pvw > PVW'(SIZE_MAX)) ? SIZE_MAX : pvw[SIZE_BITS-1:0];
					ph_q  <= (pvh > PVW'(SIZE_MAX)) ? SIZE_MAX : pvh[SIZE_BITS-1:0];
					seq_q <= SEQ_GOBS;
				end
				SEQ_GOBS: begin
					gobs_q <= gprod[GOBS_BITS+5:6];
					seq_q  <= SEQ_IDLE;
				end
				default: seq_q <= SEQ_IDLE;
			endcase
		end
	end

	// dividend shifts left, quotient bits shift in behind it
	always_ff @(posedge clk) begin
		if (seq_q == SEQ_LOAD) begin
			nw_q <= DIV_BITS'(iw_q) + DIV_BITS'(mw) - DIV_BITS'(1);
			nh_q <= DIV_BITS'(ih_q) + DIV_BITS'(mh) - DIV_BITS'(1);
			rw_q <= '0;
			rh_q <= '0;
		end else if (seq_q == SEQ_DIV) begin
			nw_q <= {nw_q[DIV_BITS-2:0], qw_bit};
			nh_q <= {nh_q[DIV_BITS-2:0], qh_bit};
			rw_q <= qw_bit ? (rw_sh - {1'b0, mw}) : rw_sh;
			rh_q <= qh_bit ? (rh_sh - {1'b0, mh}) : rh_sh;
		end
	end

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4 = !v_s4 || pix_out.ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign pix_in.ready = en1 && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= pix_in.valid && pix_in.ready;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// stage 1: products
	logic [COORD_BITS-1:0] block_row_c, row_g_c, gmask_c;
	logic [XW-1:0]         xb_c;
	logic [BW-1:0]         bprod_c;
	logic [RPW-1:0]        rowpw_c;

	logic [63:0]           data_s1, data_s2, data_s3, data_s4;
	logic [COORD_BITS-1:0] col_s1;
	logic [2:0]            row_lo_s1;
	logic [PAD_BITS-1:0]   gib_s1;
	logic [XW-1:0]         xb_s1;
	logic [BW-1:0]         bprod_s1;
	logic [RPW-1:0]        rowpw_s1;
	logic                  inb_s1, inb_s2, inb_s3;

	always_comb begin
		block_row_c = pix_in.row >> ({1'b0, bhl_q} + 4'd3);
		row_g_c     = pix_in.row >> 3;
		gmask_c     = COORD_BITS'((8'd1 << bhl_q) - 8'd1);
		xb_c        = XW'(pix_in.col) * XW'(bpt_q);
		bprod_c     = BW'(block_row_c) * BW'(gobs_q);
		rowpw_c     = RPW'(pix_in.row) * RPW'(pw_q);
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			data_s1   <= pix_in.texel_data;
			col_s1    <= pix_in.col;
			row_lo_s1 <= pix_in.row[2:0];
			gib_s1    <= PAD_BITS'(row_g_c & gmask_c);
			xb_s1     <= xb_c;
			bprod_s1  <= bprod_c;
			rowpw_s1  <= rowpw_c;
			inb_s1    <= (CXW'(pix_in.col) < CXW'(pw_q))
			          && (CXW'(pix_in.row) < CXW'(ph_q));
		end
	end

	// stage 2: address and linear sums
	logic [4:0]    sh_c;
	logic [AW-1:0] addr_c, addr_s2, addr_s3, addr_s4;
	logic [LW-1:0] lin_c, lin_s2;

	always_comb begin
		sh_c   = {2'b00, bhl_q} + 5'd9;
		addr_c = (AW'(bprod_s1) << sh_c)
		       + (AW'(xb_s1 >> 6) << sh_c)
		       + AW'({gib_s1, xb_s1[5], row_lo_s1[2:1], xb_s1[4], row_lo_s1[0], xb_s1[3:0]});
		lin_c  = LW'(rowpw_s1) + LW'(col_s1) + LW'(1);
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			data_s2 <= data_s1;
			inb_s2  <= inb_s1;
			addr_s2 <= addr_c;
			lin_s2  <= lin_c;
		end
	end

	// stage 3: linear byte end and address range
	logic [LPW-1:0] linear_s3;
	logic           aok_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			data_s3   <= data_s2;
			inb_s3    <= inb_s2;
			addr_s3   <= addr_s2;
			linear_s3 <= LPW'(lin_s2) * LPW'(bpt_q);
			aok_s3    <= (addr_s2 + AW'(bpt_q)) <= AW'(tot_q);
		end
	end

	// stage 4: output word
	logic we_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			data_s4 <= data_s3;
			addr_s4 <= addr_s3;
			we_s4   <= inb_s3 && aok_s3 && (AW'(linear_s3) <= AW'(tot_q));
		end
	end

	assign pix_out.valid        = v_s4;
	assign pix_out.dest_address = addr_s4[ADDR_BITS-1:0];
	assign pix_out.texel_out    = data_s4;
	assign pix_out.write_enable = we_s4;

endmodule
